/* rtl/pse_pkg.sv */
// Package: shared types, codes and sizes of the postfix stack evaluator.
`timescale 1ns / 1ps
package pse_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    localparam logic [4:0] CMD_PUSH = 5'd0;
    localparam logic [4:0] CMD_NOT  = 5'd1;
    localparam logic [4:0] CMD_INV  = 5'd2;
    localparam logic [4:0] CMD_NEG  = 5'd3;
    localparam logic [4:0] CMD_MUL  = 5'd4;
    localparam logic [4:0] CMD_DIV  = 5'd5;
    localparam logic [4:0] CMD_MOD  = 5'd6;
    localparam logic [4:0] CMD_ADD  = 5'd7;
    localparam logic [4:0] CMD_SUB  = 5'd8;
    localparam logic [4:0] CMD_SHL  = 5'd9;
    localparam logic [4:0] CMD_SHR  = 5'd10;
    localparam logic [4:0] CMD_LT   = 5'd11;
    localparam logic [4:0] CMD_GT   = 5'd12;
    localparam logic [4:0] CMD_LE   = 5'd13;
    localparam logic [4:0] CMD_GE   = 5'd14;
    localparam logic [4:0] CMD_EQ   = 5'd15;
    localparam logic [4:0] CMD_NE   = 5'd16;
    localparam logic [4:0] CMD_AND  = 5'd17;
    localparam logic [4:0] CMD_XOR  = 5'd18;
    localparam logic [4:0] CMD_OR   = 5'd19;
    localparam logic [4:0] CMD_LAND = 5'd20;
    localparam logic [4:0] CMD_LOR  = 5'd21;

    typedef struct packed {
        logic [4:0]        cmd;
        logic [DATA_W-1:0] operand;
        logic              operand_bad;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              error;
    } result_t;

    typedef enum logic [1:0] {
        CLS_PUSH   = 2'd0,
        CLS_UNARY  = 2'd1,
        CLS_BINARY = 2'd2,
        CLS_NONE   = 2'd3
    } cmd_class_t;

    typedef struct packed {
        logic load_item;
        logic push;
        logic unary;
        logic set_err;
        logic rd_req;
        logic alu;
        logic div_start;
        logic div_load;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        cmd_class_t item_class;
        logic       item_divides;
        logic       item_bad;
        logic       item_last;
        logic       depth_zero;
        logic       depth_full;
        logic       depth_lt2;
        logic       err;
        logic       div_busy;
        logic       out_free;
    } dp_status_t;

    function automatic cmd_class_t classify(input logic [4:0] code);
        cmd_class_t cls;
        if (code == CMD_PUSH)
            cls = CLS_PUSH;
        else if (code <= CMD_NEG)
            cls = CLS_UNARY;
        else if (code <= CMD_LOR)
            cls = CLS_BINARY;
        else
            cls = CLS_NONE;
        return cls;
    endfunction

endpackage

/* rtl/pse_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/pse_dp.sv */
// Datapath: item register, cached stack top, stack RAM, ALU, divider, result register.
`timescale 1ns / 1ps
module pse_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  pse_pkg::dp_cmd_t    cmd,
    output pse_pkg::dp_status_t status,
    input  pse_pkg::item_t      item,
    output logic                result_valid,
    input  logic                result_stall,
    output pse_pkg::result_t    result
);

    pse_pkg::item_t                    item_reg;
    logic [pse_pkg::DEPTH_W-1:0]       depth_reg, depth_next;
    logic                              err_reg, err_next;
    logic [pse_pkg::DATA_W-1:0]        top_reg, top_next;
    logic [pse_pkg::DATA_W-1:0]        quo_reg, quo_next;
    logic [pse_pkg::DATA_W-1:0]        rem_reg, rem_next;
    logic [pse_pkg::DATA_W-1:0]        den_reg, den_next;
    logic [pse_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                              div_busy_reg, div_busy_next;
    pse_pkg::result_t                  result_reg, result_next;
    logic                              result_valid_reg, result_valid_next;

    logic [pse_pkg::DEPTH_W-1:0]       depth_m1, depth_m2;
    logic [pse_pkg::DATA_W-1:0]        below;
    logic [pse_pkg::DATA_W-1:0]        unary_res, alu_res, div_res;
    logic [pse_pkg::DATA_W:0]          rem_sh;
    logic                              rem_ge;
    logic                              shift_ok;

    assign depth_m1 = depth_reg - pse_pkg::DEPTH_W'(1);
    assign depth_m2 = depth_reg - pse_pkg::DEPTH_W'(2);

    pse_ram #(
        .WIDTH (pse_pkg::DATA_W),
        .DEPTH (pse_pkg::STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (cmd.push && (depth_reg != '0)),
        .wr_addr (depth_m1[pse_pkg::ADDR_W-1:0]),
        .wr_data (top_reg),
        .rd_en   (cmd.rd_req),
        .rd_addr (depth_m2[pse_pkg::ADDR_W-1:0]),
        .rd_data (below)
    );

    always_comb
    begin
        unique case (item_reg.cmd)
            pse_pkg::CMD_NOT: unary_res = (top_reg == '0) ? pse_pkg::DATA_W'(1) : '0;
            pse_pkg::CMD_INV: unary_res = ~top_reg;
            default:          unary_res = '0 - top_reg;
        endcase
    end

    assign shift_ok = (top_reg[pse_pkg::DATA_W-1:5] == '0);

    always_comb
    begin
        unique case (item_reg.cmd)
            pse_pkg::CMD_MUL:  alu_res = below * top_reg;
            pse_pkg::CMD_ADD:  alu_res = below + top_reg;
            pse_pkg::CMD_SUB:  alu_res = below - top_reg;
            pse_pkg::CMD_SHL:  alu_res = shift_ok ? (below << top_reg[4:0]) : '0;
            pse_pkg::CMD_SHR:  alu_res = shift_ok ? (below >> top_reg[4:0]) : '0;
            pse_pkg::CMD_LT:   alu_res = pse_pkg::DATA_W'(below < top_reg);
            pse_pkg::CMD_GT:   alu_res = pse_pkg::DATA_W'(below > top_reg);
            pse_pkg::CMD_LE:   alu_res = pse_pkg::DATA_W'(below <= top_reg);
            pse_pkg::CMD_GE:   alu_res = pse_pkg::DATA_W'(below >= top_reg);
            pse_pkg::CMD_EQ:   alu_res = pse_pkg::DATA_W'(below == top_reg);
            pse_pkg::CMD_NE:   alu_res = pse_pkg::DATA_W'(below != top_reg);
            pse_pkg::CMD_AND:  alu_res = below & top_reg;
            pse_pkg::CMD_XOR:  alu_res = below ^ top_reg;
            pse_pkg::CMD_OR:   alu_res = below | top_reg;
            pse_pkg::CMD_LAND: alu_res = pse_pkg::DATA_W'((below != '0) && (top_reg != '0));
            pse_pkg::CMD_LOR:  alu_res = pse_pkg::DATA_W'((below != '0) || (top_reg != '0));
            default:           alu_res = below;
        endcase
    end

    // restoring divider, one quotient bit per cycle
    assign rem_sh = {rem_reg, quo_reg[pse_pkg::DATA_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, den_reg});

    always_comb
    begin
        if (den_reg == '0)
            div_res = '0;
        else if (item_reg.cmd == pse_pkg::CMD_MOD)
            div_res = rem_reg;
        else
            div_res = quo_reg;
    end

    always_comb
    begin
        depth_next        = depth_reg;
        err_next          = err_reg;
        top_next          = top_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        den_next          = den_reg;
        cnt_next          = cnt_reg;
        div_busy_next     = div_busy_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        if (cmd.set_err)
            err_next = 1'b1;
        if (cmd.push)
        begin
            top_next   = item_reg.operand;
            depth_next = depth_reg + pse_pkg::DEPTH_W'(1);
        end
        if (cmd.unary)
            top_next = unary_res;
        if (cmd.alu)
        begin
            top_next   = alu_res;
            depth_next = depth_m1;
        end
        if (cmd.div_start)
        begin
            quo_next      = below;
            den_next      = top_reg;
            rem_next      = '0;
            cnt_next      = pse_pkg::DIV_CNT_W'(pse_pkg::DIV_STEPS);
            div_busy_next = 1'b1;
        end
        else if (div_busy_reg)
        begin
            if (rem_ge)
            begin
                rem_next = pse_pkg::DATA_W'(rem_sh - {1'b0, den_reg});
                quo_next = {quo_reg[pse_pkg::DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[pse_pkg::DATA_W-1:0];
                quo_next = {quo_reg[pse_pkg::DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - pse_pkg::DIV_CNT_W'(1);
            if (cnt_reg == pse_pkg::DIV_CNT_W'(1))
                div_busy_next = 1'b0;
        end
        if (cmd.div_load)
        begin
            top_next   = div_res;
            depth_next = depth_m1;
        end
        if (cmd.out_load)
        begin
            if (err_reg || (depth_reg != pse_pkg::DEPTH_W'(1)))
            begin
                result_next.value = '0;
                result_next.error = 1'b1;
            end
            else
            begin
                result_next.value = top_reg;
                result_next.error = 1'b0;
            end
            result_valid_next = 1'b1;
            depth_next        = '0;
            err_next          = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg        <= '0;
            err_reg          <= 1'b0;
            div_busy_reg     <= 1'b0;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg        <= depth_next;
            err_reg          <= err_next;
            div_busy_reg     <= div_busy_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= item;
        top_reg    <= top_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        status.item_class   = pse_pkg::classify(item_reg.cmd);
        status.item_divides = (item_reg.cmd == pse_pkg::CMD_DIV) ||
                              (item_reg.cmd == pse_pkg::CMD_MOD);
        status.item_bad     = item_reg.operand_bad;
        status.item_last    = item_reg.last;
        status.depth_zero   = (depth_reg == '0);
        status.depth_full   = (depth_reg == pse_pkg::DEPTH_W'(pse_pkg::STACK_DEPTH));
        status.depth_lt2    = (depth_reg < pse_pkg::DEPTH_W'(2));
        status.err          = err_reg;
        status.div_busy     = div_busy_reg;
        status.out_free     = !result_valid_reg || !result_stall;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* rtl/pse_ctrl.sv */
// Controller: state machine that sequences one item through the datapath.
`timescale 1ns / 1ps
module pse_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  pse_pkg::dp_status_t status,
    output pse_pkg::dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_OPER = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    state_t done_state;

    assign done_state = status.item_last ? ST_FIN : ST_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = done_state;
                if (!status.err)
                begin
                    unique case (status.item_class)
                        pse_pkg::CLS_PUSH:
                        begin
                            if (status.depth_full || status.item_bad)
                                cmd.set_err = 1'b1;
                            else
                                cmd.push = 1'b1;
                        end
                        pse_pkg::CLS_UNARY:
                        begin
                            if (status.depth_zero)
                                cmd.set_err = 1'b1;
                            else
                                cmd.unary = 1'b1;
                        end
                        pse_pkg::CLS_BINARY:
                        begin
                            if (status.depth_lt2)
                                cmd.set_err = 1'b1;
                            else
                            begin
                                cmd.rd_req = 1'b1;
                                state_next = ST_OPER;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_OPER:
            begin
                if (status.item_divides)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    cmd.alu    = 1'b1;
                    state_next = done_state;
                end
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = done_state;
                end
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign item_stall = (state_reg != ST_IDLE);

endmodule

/* rtl/postfix_stack_evaluator_core.sv */
// Top level: postfix expression evaluator on a 32-bit operand stack.
//
//  channel  direction  signals                              carries
//  item     in         item_valid, item_stall, item         one expression token
//  result   out        result_valid, result_stall, result   value and error flag
//
// Push, unary and no-op items pass through ST_EXEC only; binary items go on to
// ST_OPER (read of the entry below the top from the stack RAM, then the ALU).
// Divide and modulo then run the restoring divider in ST_DIV.
// A last item then passes through ST_FIN to load the result register; it waits there
// while an earlier result is still stalled, and no item is taken meanwhile.
// Reset clears depth, sticky error and all control; the stack RAM needs no clearing.
`timescale 1ns / 1ps
module postfix_stack_evaluator_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  pse_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output pse_pkg::result_t result
);

    pse_pkg::dp_cmd_t    dp_cmd;
    pse_pkg::dp_status_t dp_status;

    pse_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (dp_status),
        .cmd        (dp_cmd)
    );

    pse_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* rtl/pse_checker.sv */
// Checker: port-level assertions on the evaluator, bound to the top level.
`timescale 1ns / 1ps
module pse_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_stall,
    input pse_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_stall,
    input pse_pkg::result_t result
);

    // an errored result never carries a value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.error) |-> (result.value == '0))
    else $error("result with error carries a nonzero value");

    // a stalled result transaction holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

    // one item in flight: busy right after an accepted transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
    else $error("item accepted while previous item in flight");

    // a non-last item cannot produce a result the next cycle
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && !item.last && !result_valid) |=> !result_valid)
    else $error("result appeared without a last item");

endmodule

bind postfix_stack_evaluator_core pse_checker u_pse_checker (.*);

/* dv/postfix_stack_evaluator_core_tb.sv */
// Testbench: postfix stack evaluator core, scoreboarded against a stack-machine predictor.
`timescale 1ns / 1ps
module postfix_stack_evaluator_core_tb;

    localparam logic [4:0] CMD_SPARE_TOP = 5'd31;
    localparam int         ITEM_TARGET   = 650;
    localparam int         SETTLE_CYCLES = 40;

    class expr_scoreboard;
        logic [pse_pkg::DATA_W-1:0] stk [pse_pkg::STACK_DEPTH];
        int                         depth;
        bit                         sticky;
        pse_pkg::result_t           pending_results[$];
        int                         items_seen;
        int                         fails;
        int                         shown;

        function new();
            depth      = 0;
            sticky     = 1'b0;
            items_seen = 0;
            fails      = 0;
            shown      = 0;
        endfunction

        function logic [pse_pkg::DATA_W-1:0] eval_op(logic [4:0] code,
                                                     logic [pse_pkg::DATA_W-1:0] a,
                                                     logic [pse_pkg::DATA_W-1:0] b);
            case (code)
                pse_pkg::CMD_MUL:  return a * b;
                pse_pkg::CMD_DIV:  return (b != 0) ? a / b : '0;
                pse_pkg::CMD_MOD:  return (b != 0) ? a % b : '0;
                pse_pkg::CMD_ADD:  return a + b;
                pse_pkg::CMD_SUB:  return a - b;
                pse_pkg::CMD_SHL:  return (b < 32) ? a << b[4:0] : '0;
                pse_pkg::CMD_SHR:  return (b < 32) ? a >> b[4:0] : '0;
                pse_pkg::CMD_LT:   return pse_pkg::DATA_W'(a < b);
                pse_pkg::CMD_GT:   return pse_pkg::DATA_W'(a > b);
                pse_pkg::CMD_LE:   return pse_pkg::DATA_W'(a <= b);
                pse_pkg::CMD_GE:   return pse_pkg::DATA_W'(a >= b);
                pse_pkg::CMD_EQ:   return pse_pkg::DATA_W'(a == b);
                pse_pkg::CMD_NE:   return pse_pkg::DATA_W'(a != b);
                pse_pkg::CMD_AND:  return a & b;
                pse_pkg::CMD_XOR:  return a ^ b;
                pse_pkg::CMD_OR:   return a | b;
                pse_pkg::CMD_LAND: return pse_pkg::DATA_W'((a != 0) && (b != 0));
                pse_pkg::CMD_LOR:  return pse_pkg::DATA_W'((a != 0) || (b != 0));
                default:           return a;
            endcase
        endfunction

        function void note_token(pse_pkg::item_t it);
            pse_pkg::result_t             r;
            logic [pse_pkg::ADDR_W-1:0]   ti;
            logic [pse_pkg::ADDR_W-1:0]   bi;
            ti = pse_pkg::ADDR_W'(depth - 1);
            bi = pse_pkg::ADDR_W'(depth - 2);
            items_seen++;
            if (!sticky)
            begin
                if (it.cmd == pse_pkg::CMD_PUSH)
                begin
                    if (depth >= pse_pkg::STACK_DEPTH || it.operand_bad)
                        sticky = 1'b1;
                    else
                    begin
                        stk[pse_pkg::ADDR_W'(depth)] = it.operand;
                        depth++;
                    end
                end
                else if (it.cmd <= pse_pkg::CMD_NEG)
                begin
                    if (depth < 1)
                        sticky = 1'b1;
                    else if (it.cmd == pse_pkg::CMD_NOT)
                        stk[ti] = pse_pkg::DATA_W'(stk[ti] == 0);
                    else if (it.cmd == pse_pkg::CMD_INV)
                        stk[ti] = ~stk[ti];
                    else
                        stk[ti] = -stk[ti];
                end
                else if (it.cmd <= pse_pkg::CMD_LOR)
                begin
                    if (depth < 2)
                        sticky = 1'b1;
                    else
                    begin
                        stk[bi] = eval_op(it.cmd, stk[bi], stk[ti]);
                        depth--;
                    end
                end
            end
            if (it.last)
            begin
                r.error = sticky || depth != 1;
                r.value = r.error ? '0 : stk[0];
                pending_results.insert(pending_results.size(), r);
                sticky = 1'b0;
                depth  = 0;
            end
        endfunction

        function void report(string what, logic [pse_pkg::DATA_W-1:0] exp_v,
                             logic [pse_pkg::DATA_W-1:0] got_v);
            fails++;
            if (shown < 10)
            begin
                shown++;
                $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, got_v);
            end
        endfunction

        function void check_result(pse_pkg::result_t got);
            pse_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                report("unexpected transaction, value", '0, got.value);
                return;
            end
            want = pending_results.pop_front();
            if (got.value !== want.value)
                report("value", want.value, got.value);
            if (got.error !== want.error)
                report("error", pse_pkg::DATA_W'(want.error), pse_pkg::DATA_W'(got.error));
        endfunction
    endclass

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    pse_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    pse_pkg::result_t result;

    expr_scoreboard sb;
    bit             quiet   = 1'b0;
    int             rx_hold = 0;

    postfix_stack_evaluator_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check_result(result);
            rx_hold <= quiet ? 0 : $urandom_range(0, 8);
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            result_stall <= 1'b1;
            rx_hold      <= rx_hold - 1;
        end
        else
            result_stall <= 1'b0;
    end

    task automatic send_item(pse_pkg::item_t it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        forever
        begin
            @(posedge clk);
            if (!item_stall)
                break;
        end
        sb.note_token(it);
    endtask

    task automatic tok(logic [4:0] cmd, logic [pse_pkg::DATA_W-1:0] opnd, logic bad,
                       logic lst);
        pse_pkg::item_t it;
        it.cmd         = cmd;
        it.operand     = opnd;
        it.operand_bad = bad;
        it.last        = lst;
        send_item(it);
    endtask

    task automatic drain_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [pse_pkg::DATA_W-1:0] draw_operand();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 1;
            3:       return 32'h8000_0000;
            4, 5:    return pse_pkg::DATA_W'($urandom_range(0, 40));
            default: return $urandom;
        endcase
    endfunction

    task automatic run_expression(bit deep);
        pse_pkg::item_t q[$];
        pse_pkg::item_t t;
        int             want;
        int             d;
        int             pushed;
        int             keep;
        want   = deep ? $urandom_range(62, 66) : $urandom_range(1, 10);
        d      = 0;
        pushed = 0;
        while (pushed < want || d > 1)
        begin
            t         = '0;
            t.operand = draw_operand();
            if (pushed < want && (deep || d < 2 || $urandom_range(0, 1) == 0))
            begin
                t.cmd = pse_pkg::CMD_PUSH;
                pushed++;
                if (d < pse_pkg::STACK_DEPTH)
                    d++;
            end
            else if ($urandom_range(0, 3) == 0)
                t.cmd = 5'($urandom_range(pse_pkg::CMD_NOT, pse_pkg::CMD_NEG));
            else
            begin
                t.cmd = 5'($urandom_range(pse_pkg::CMD_MUL, pse_pkg::CMD_LOR));
                d--;
            end
            // occasional broken token: stray code, failed fetch
            if ($urandom_range(0, 39) == 0)
            begin
                t.cmd         = 5'($urandom_range(0, 31));
                t.operand_bad = 1'($urandom_range(0, 1));
            end
            q.insert(q.size(), t);
        end
        if ($urandom_range(0, 14) == 0)
        begin
            keep = $urandom_range(1, q.size());
            while (q.size() > keep)
                q.delete(q.size() - 1);
        end
        q[q.size()-1].last = 1'b1;
        foreach (q[i])
            send_item(q[i]);
    endtask

    initial
    begin
        int n;
        sb = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // mod by zero, negate of zero, all-ones operand
        tok(pse_pkg::CMD_PUSH, '1, 1'b0, 1'b0);
        tok(pse_pkg::CMD_PUSH, '0, 1'b0, 1'b0);
        tok(pse_pkg::CMD_MOD,  '0, 1'b0, 1'b0);
        tok(pse_pkg::CMD_NEG,  '1, 1'b0, 1'b1);
        // shift by 32, not, spare code
        tok(pse_pkg::CMD_PUSH, 1, 1'b0, 1'b0);
        tok(pse_pkg::CMD_PUSH, 32, 1'b0, 1'b0);
        tok(pse_pkg::CMD_SHL,  '0, 1'b0, 1'b0);
        tok(pse_pkg::CMD_NOT,  '0, 1'b0, 1'b0);
        tok(CMD_SPARE_TOP, '1, 1'b1, 1'b1);
        // underflow on binary, then a push that is ignored
        tok(pse_pkg::CMD_PUSH, 5, 1'b0, 1'b0);
        tok(pse_pkg::CMD_ADD,  '0, 1'b0, 1'b0);
        tok(pse_pkg::CMD_PUSH, 9, 1'b0, 1'b1);
        // failed fetch
        tok(pse_pkg::CMD_PUSH, 3, 1'b1, 1'b0);
        tok(pse_pkg::CMD_PUSH, 4, 1'b0, 1'b1);
        // unary on empty stack
        tok(pse_pkg::CMD_INV,  '0, 1'b0, 1'b1);
        // invert, logical shift right by 31
        tok(pse_pkg::CMD_PUSH, '0, 1'b0, 1'b0);
        tok(pse_pkg::CMD_INV,  '0, 1'b0, 1'b0);
        tok(pse_pkg::CMD_PUSH, 31, 1'b0, 1'b0);
        tok(pse_pkg::CMD_SHR,  '0, 1'b0, 1'b1);
        // two entries left at the end
        tok(pse_pkg::CMD_PUSH, 1, 1'b0, 1'b0);
        tok(pse_pkg::CMD_PUSH, 2, 1'b0, 1'b1);
        // single zero
        tok(pse_pkg::CMD_PUSH, '0, 1'b0, 1'b1);
        drain_results();

        n = 0;
        while (sb.items_seen < ITEM_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
                quiet = ~quiet;
            run_expression(n == 15 || n == 40 || n == 70);
            if (n == 30)
                drain_results();
            n++;
        end

        @(negedge clk);
        item_valid <= 1'b0;
        quiet = 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending_results.size() != 0)
            sb.fails++;
        if (sb.fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
